// ===== hdl/b2pbcd_pkg.sv =====
package b2pbcd_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned CYCLE_W = 6;   // counts the VALUE_W shift steps
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [7:0]         bcd_byte;
		logic [COUNT_W-1:0] byte_index;
		logic               last;
	} res_t;

	// classified request: count already clamped and known to be nonzero
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} job_t;

	function automatic logic [3:0] dabble(input logic [3:0] nib);
		dabble = (nib >= 4'd5) ? nib + 4'd3 : nib;
	endfunction

endpackage

// ===== hdl/binary_to_packed_bcd.sv =====
// Converts a 64-bit unsigned value to byte_count packed BCD bytes (clamped to
// MAX_BCD_BYTES, a count of zero produces nothing), most significant pair first,
// with last set on the final byte; decimal digits above the requested width are
// dropped silently. The converter takes each request from the queue, runs the
// bit-serial shift-and-add-3 loop one value bit at a time, then emits one byte
// per cycle while res_stall does not hold a waiting result. A two-entry queue
// between the input stage and the converter lets the input keep taking requests
// during a conversion or a res_stall wait, until the queue and input stage fill.
module binary_to_packed_bcd import b2pbcd_pkg::*; #(
	parameter int unsigned MAX_BCD_BYTES = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_stall,
	output logic res_valid,
	output res_t res,
	input  logic res_stall
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t job_in;
	job_t job_out;

	b2pbcd_front #(.MAX_BCD_BYTES(MAX_BCD_BYTES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.q_full(q_full),
		.push(push),
		.job(job_in)
	);

	b2pbcd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.job_in(job_in),
		.full(q_full),
		.pop(pop),
		.empty(q_empty),
		.job_out(job_out)
	);

	b2pbcd_back #(.MAX_BCD_BYTES(MAX_BCD_BYTES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.job(job_out),
		.pop(pop),
		.res_valid(res_valid),
		.res(res),
		.res_stall(res_stall)
	);

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.bcd_byte[7:4] <= 4'd9) && (res.bcd_byte[3:0] <= 4'd9))
		else $error("non-decimal digit in result");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.byte_index < COUNT_W'(MAX_BCD_BYTES)))
		else $error("byte index beyond maximum");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !res.last) |=>
		(res_valid && (res.byte_index == $past(res.byte_index) + 4'd1)))
		else $error("gap or misorder inside a byte burst");

endmodule

// ===== hdl/b2pbcd_front.sv =====
module b2pbcd_front import b2pbcd_pkg::*; #(
	parameter int unsigned MAX_BCD_BYTES = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_stall,
	input  logic q_full,
	output logic push,
	output job_t job
);

	logic               v_s1;
	job_t               job_s1;
	logic               accept;
	logic [COUNT_W-1:0] count_c;

	assign req_stall = v_s1 && q_full;
	assign accept = req_valid && !req_stall;
	assign push = v_s1 && !q_full;
	assign job = job_s1;

	// saturate the count; a zero count yields nothing
	assign count_c = (req.byte_count > COUNT_W'(MAX_BCD_BYTES)) ?
		COUNT_W'(MAX_BCD_BYTES) : req.byte_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			priority if (accept && count_c != '0) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= '{value: req.value, count: count_c};
		end
	end

endmodule

// ===== hdl/b2pbcd_queue.sv =====
module b2pbcd_queue import b2pbcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t job_out
);

	job_t                mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     fill_q;

	assign full = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (fill_q == '0);
	assign job_out = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= job_in;
		end
	end

endmodule

// ===== hdl/b2pbcd_back.sv =====
module b2pbcd_back import b2pbcd_pkg::*; #(
	parameter int unsigned MAX_BCD_BYTES = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  job_t job,
	output logic pop,
	output logic res_valid,
	output res_t res,
	input  logic res_stall
);

	localparam int unsigned DIGITS = 2 * MAX_BCD_BYTES;
	localparam int unsigned BCD_W = 4 * DIGITS;
	localparam int unsigned IDX_W = (MAX_BCD_BYTES > 1) ? $clog2(MAX_BCD_BYTES) : 1;

	typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] val_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CYCLE_W-1:0] step_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] k_q;
	logic               res_valid_q;
	res_t               res_q;
	logic [BCD_W-1:0]   adj;
	logic [7:0]         pairs [MAX_BCD_BYTES];
	logic               slot_free;

	assign pop = (state_q == IDLE) && !empty;
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// add 3 to every digit at 5 or above before the next shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			adj[4*d +: 4] = dabble(bcd_q[4*d +: 4]);
		end
	end

	always_comb begin
		for (int b = 0; b < MAX_BCD_BYTES; b++) begin
			pairs[b] = bcd_q[8*b +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			val_q <= '0;
			bcd_q <= '0;
			step_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			// a free slot is refilled only while emitting
			if (slot_free) begin
				res_valid_q <= (state_q == EMIT);
			end
			unique case (state_q)
				IDLE: begin
					if (!empty) begin
						val_q <= job.value;
						bcd_q <= '0;
						step_q <= '0;
						idx_q <= IDX_W'(job.count - 1'b1);
						k_q <= '0;
						state_q <= CONV;
					end
				end
				CONV: begin
					bcd_q <= {adj[BCD_W-2:0], val_q[VALUE_W-1]};
					val_q <= {val_q[VALUE_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == CYCLE_W'(VALUE_W - 1)) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (slot_free) begin
						res_q <= '{bcd_byte: pairs[idx_q], byte_index: k_q,
							last: (idx_q == '0)};
						k_q <= k_q + 1'b1;
						idx_q <= idx_q - 1'b1;
						if (idx_q == '0) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== verif/binary_to_packed_bcd_tb.sv =====
module binary_to_packed_bcd_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b2pbcd_pkg::*;

	localparam int unsigned MAX_BYTES   = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_OFF    = 800;
	localparam int unsigned PHASE_ITEMS = 110;
	localparam int unsigned FILL_ITEMS  = 40;

	class bcd_checker;
		res_t        expected_bytes[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned zero_requests;
		int unsigned clamped_requests;
		int unsigned bytes_checked;

		// Split the value into decimal pairs, least significant pair in the last byte.
		function void note_request(req_t r);
			logic [VALUE_W-1:0] rest;
			logic [7:0]         pairs [MAX_BYTES];
			int unsigned        n;
			int unsigned        pair;
			res_t               e;
			requests++;
			if (r.byte_count == '0)
				zero_requests++;
			if (r.byte_count > MAX_BYTES)
				clamped_requests++;
			n = (r.byte_count > MAX_BYTES) ? MAX_BYTES : int'(r.byte_count);
			rest = r.value;
			for (int k = n; k > 0; k--) begin
				pair = int'(rest % 64'd100);
				pairs[k-1] = {4'(pair / 10), 4'(pair % 10)};
				rest = rest / 64'd100;
			end
			for (int k = 0; k < n; k++) begin
				e.bcd_byte   = pairs[k];
				e.byte_index = COUNT_W'(k);
				e.last       = (k == n - 1);
				expected_bytes.push_back(e);
			end
		endfunction

		function void check_byte(res_t got);
			res_t e;
			if (expected_bytes.size() == 0) begin
				$error("unexpected BCD byte %h, index %0d, last %b",
					got.bcd_byte, got.byte_index, got.last);
				errors++;
				return;
			end
			e = expected_bytes.pop_front();
			bytes_checked++;
			if (got.bcd_byte !== e.bcd_byte) begin
				$error("bcd_byte: expected %h, actual %h", e.bcd_byte, got.bcd_byte);
				errors++;
			end
			if (got.byte_index !== e.byte_index) begin
				$error("byte_index: expected %0d, actual %0d", e.byte_index, got.byte_index);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %b, actual %b", e.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	req_t req;
	logic req_stall;
	logic res_valid;
	res_t res;
	logic res_stall;

	bcd_checker  chk;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;
	int unsigned cycles;

	binary_to_packed_bcd #(
		.MAX_BCD_BYTES(MAX_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res      (res),
		.res_stall(res_stall)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Output side: a long hold-off overrides the random stall.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				chk.note_request(req);
			if (res_valid && !res_stall)
				chk.check_byte(res);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic req_t make_request(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count);
		req_t r;
		r.value      = value;
		r.byte_count = count;
		return r;
	endfunction

	function automatic req_t random_request();
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		int unsigned        pick;
		logic [COUNT_W-1:0] n;
		pick = $urandom_range(99);
		if (pick < 6)
			n = '0;
		else if (pick < 12)
			n = COUNT_W'($urandom_range(15, MAX_BYTES + 1));
		else
			n = COUNT_W'($urandom_range(MAX_BYTES, 1));
		case ($urandom_range(3))
			0: v = {$urandom, $urandom};
			1: v = VALUE_W'($urandom_range(9999));
			2: begin
				// straddle a power of ten
				p = 64'd1;
				repeat ($urandom_range(19, 1)) p = p * 64'd10;
				v = p + VALUE_W'($urandom_range(2)) - 64'd1;
			end
			default: v = {$urandom, $urandom} >> $urandom_range(63);
		endcase
		return make_request(v, n);
	endfunction

	task automatic send_request(req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop offering and let every pending byte come out.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned items, int unsigned idle_pct, int unsigned stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items) send_request(random_request());
		drain();
	endtask

	initial begin
		chk            = new();
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		res_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(make_request(64'd0, 4'd1));
		send_request(make_request(64'd0, 4'd10));
		send_request(make_request('1, 4'd10));
		send_request(make_request('1, 4'd15));
		send_request(make_request('1, 4'd0));
		send_request(make_request(64'd99, 4'd1));
		send_request(make_request(64'd100, 4'd1));
		send_request(make_request(64'd12345678901234567890, 4'd10));
		send_request(make_request(64'd9999999999, 4'd5));
		send_request(make_request(64'd9999999999, 4'd4));
		send_request(make_request(64'd1, 4'd10));
		send_request(make_request(64'hAAAA_AAAA_AAAA_AAAA, 4'd11));
		send_request(make_request(64'h5555_5555_5555_5555, 4'd12));
		send_request(make_request(64'd10000000000000000000, 4'd10));
		send_request(make_request(64'd987654321, 4'd13));
		send_request(make_request(64'd42, 4'd14));
		send_request(make_request('1, 4'd1));
		send_request(make_request(64'd1000000, 4'd3));
		send_request(make_request(64'd999999, 4'd3));
		send_request(make_request(64'h8000_0000_0000_0000, 4'd9));
		send_request(make_request(64'd0, 4'd0));
		send_request(make_request(64'd7, 4'd2));
		drain();

		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 59, 0);
		run_phase(PHASE_ITEMS, 0, 59);
		run_phase(PHASE_ITEMS, 14, 14);

		// Hold the output long enough for the input to back up.
		@(posedge clk);
		hold_cycles = HOLD_OFF;
		run_phase(FILL_ITEMS, 0, 0);

		repeat (100) @(posedge clk);
		$display("Covered %0d requests (%0d with zero count, %0d clamped), %0d BCD bytes checked",
			chk.requests, chk.zero_requests, chk.clamped_requests, chk.bytes_checked);
		$display("Idling mixes: none, sender, receiver, both, then a %0d-cycle output hold-off",
			HOLD_OFF);
		if (chk.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/b2pbcd_pkg.sv
hdl/b2pbcd_front.sv
hdl/b2pbcd_queue.sv
hdl/b2pbcd_back.sv
hdl/binary_to_packed_bcd.sv
verif/binary_to_packed_bcd_tb.sv
